### hdl/plra_pkg.sv
// ----------------------------------------------------------------------------
// plra_pkg: shared types and constants of the power-limit request arbiter
// Word layouts, command and register codes, sequencer states, ALU interface.
// ----------------------------------------------------------------------------
package plra_pkg;

  localparam int unsigned PowerBits = 20;
  localparam int unsigned AluBits   = PowerBits + 1;

  typedef enum logic [2:0] {
    KindLimit       = 3'd0,
    KindUnlimit     = 3'd1,
    KindCommit      = 3'd2,
    KindClearTarget = 3'd3,
    KindClearAll    = 3'd4
  } plra_kind_e;

  typedef enum logic [1:0] {
    RegControls = 2'd0,
    RegMinLimit = 2'd1,
    RegMaxLimit = 2'd2,
    RegStepSize = 2'd3
  } plra_reg_e;

  typedef struct packed {
    logic [2:0]           kind;
    logic [3:0]           target;
    logic [PowerBits-1:0] measured_power;
    logic [PowerBits-1:0] issued_limit;
  } plra_item_t;

  typedef struct packed {
    logic [PowerBits-1:0] limit_value;
    logic                 acted;
  } plra_result_t;

  typedef enum logic {
    AluAdd = 1'b0,
    AluSub = 1'b1
  } plra_alu_op_e;

  typedef struct packed {
    logic [AluBits-1:0] res;
    logic               lt;
    logic               eq;
  } plra_alu_res_t;

  typedef enum logic [4:0] {
    StIdle,
    StLoad,
    StLimChk,
    StLimMax,
    StStepSub,
    StPwrMin,
    StPwrStep,
    StPwrReq,
    StPwrLeast,
    StLimFloor,
    StUpChk,
    StUpAdd,
    StUpCap,
    StScan,
    StClampMax,
    StClampMin,
    StCmpIssued
  } plra_state_e;

endpackage

### hdl/power_limit_request_arbiter.sv
// ----------------------------------------------------------------------------
// power_limit_request_arbiter: per-target power-limit requests and commit
// Holds one request per target, steps it on limit/unlimit, and arbitrates the
// lowest request into a clamped limit on commit.
// ----------------------------------------------------------------------------
// Clears, unused kinds, out-of-range targets and commit without control support
// answer from idle with done_o in the cycle after the accept edge; limit, unlimit
// and commit run the sequencer, commit reading one slot per cycle from the memory.
// busy stays high in between and drops as the result appears, so a new word waits
// for the last; done_o cannot be stalled. Reset clears every valid bit at once with
// no clearing pass; request values stay unknown until written.
module power_limit_request_arbiter
  import plra_pkg::*;
#(
  parameter int unsigned TARGETS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command side
  input  logic         start,
  output logic         busy,
  input  plra_item_t   item_i,
  output logic         done_o,
  output plra_result_t result_o,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned W  = PowerBits;
  localparam int unsigned IW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int unsigned CW = $clog2(TARGETS + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic         ctl_q;
  logic [W-1:0] min_q, max_q, step_q;
  logic         cfg_we;
  plra_reg_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = plra_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= 1'b0;
      min_q  <= '0;
      max_q  <= '1;
      step_q <= W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegControls: ctl_q  <= pwdata[0];
        RegMinLimit: min_q  <= pwdata[W-1:0];
        RegMaxLimit: max_q  <= pwdata[W-1:0];
        RegStepSize: step_q <= pwdata[W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegControls: prdata = {31'b0, ctl_q};
      RegMinLimit: prdata = 32'(min_q);
      RegMaxLimit: prdata = 32'(max_q);
      RegStepSize: prdata = 32'(step_q);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  plra_state_e   state_q, state_d;
  plra_item_t    item_q, item_d;
  logic [W-1:0]  req_q, req_d;        // request under work
  logic [AluBits-1:0] acc_q, acc_d;   // running value of the step chain
  logic [W-1:0]  tmp_q, tmp_d;        // measured power less one step
  logic [W-1:0]  low_q, low_d;        // running minimum of a commit
  logic          any_q, any_d;
  logic [CW-1:0] idx_q, idx_d;        // scan pointer
  logic          pend_q, pend_d;      // read data holds a scanned slot
  logic          vld_q, vld_d;        // valid bit of that slot
  logic [TARGETS-1:0] valid_q, valid_d;
  logic          done_q, done_d;
  plra_result_t  result_q, result_d;

  // request memory: one write port, one registered read port
  logic [W-1:0]  mem_q [TARGETS];
  logic [W-1:0]  rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_raddr;
  logic [W-1:0]  mem_wdata;

  // shared ALU
  plra_alu_op_e       alu_op;
  logic [AluBits-1:0] alu_a, alu_b;
  plra_alu_res_t      alu;

  plra_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  logic          in_range_new, in_range_cur;
  logic [IW-1:0] tgt_new, tgt_cur;
  logic          scan_end;

  assign in_range_new = (32'(item_i.target) < 32'(TARGETS));
  assign in_range_cur = (32'(item_q.target) < 32'(TARGETS));
  assign tgt_new      = IW'(item_i.target);
  assign tgt_cur      = IW'(item_q.target);
  assign scan_end     = (idx_q == CW'(TARGETS));

  assign busy     = (state_q != StIdle);
  assign done_o   = done_q;
  assign result_o = result_q;

  always_comb begin
    unique case (state_q)
      StIdle:  mem_raddr = in_range_new ? tgt_new : '0;
      StScan:  mem_raddr = scan_end ? '0 : idx_q[IW-1:0];
      default: mem_raddr = in_range_cur ? tgt_cur : '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tgt_cur] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          case (item_i.kind) inside
            KindLimit, KindUnlimit: if (in_range_new) state_d = StLoad;
            KindCommit:             if (ctl_q) state_d = StScan;
            default:                state_d = StIdle;
          endcase
        end
      end
      StLoad:     state_d = (item_q.kind == KindLimit) ? StLimChk : StUpChk;
      StLimChk:   state_d = (ctl_q && alu.lt) ? StLimMax : StIdle;
      StLimMax:   state_d = alu.lt ? StStepSub : StPwrMin;
      StStepSub:  state_d = StLimFloor;
      StPwrMin:   state_d = alu.lt ? StPwrStep : StLimFloor;
      StPwrStep:  state_d = alu.lt ? StLimFloor : StPwrReq;
      StPwrReq:   state_d = StPwrLeast;
      StPwrLeast: state_d = StLimFloor;
      StLimFloor: state_d = StIdle;
      StUpChk:    state_d = (ctl_q && alu.lt) ? StUpAdd : StIdle;
      StUpAdd:    state_d = StUpCap;
      StUpCap:    state_d = StIdle;
      StScan:     state_d = scan_end ? StClampMax : StScan;
      StClampMax: state_d = StClampMin;
      StClampMin: state_d = StCmpIssued;
      StCmpIssued: state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    item_d    = item_q;
    req_d     = req_q;
    acc_d     = acc_q;
    tmp_d     = tmp_q;
    low_d     = low_q;
    any_d     = any_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    vld_d     = vld_q;
    valid_d   = valid_q;
    done_d    = 1'b0;
    result_d  = result_q;
    mem_we    = 1'b0;
    mem_wdata = acc_q[W-1:0];
    alu_op    = AluSub;
    alu_a     = AluBits'(req_q);
    alu_b     = AluBits'(min_q);

    unique case (state_q)
      StIdle: begin
        if (start) begin
          item_d = item_i;
          low_d  = item_i.issued_limit;
          any_d  = 1'b0;
          idx_d  = '0;
          pend_d = 1'b0;
          // single-cycle commands answer straight from here
          result_d.limit_value = '0;
          result_d.acted       = 1'b0;
          case (item_i.kind) inside
            KindLimit, KindUnlimit: done_d = !in_range_new;
            KindCommit: begin
              done_d               = !ctl_q;
              result_d.limit_value = item_i.issued_limit;
            end
            KindClearTarget: begin
              done_d = 1'b1;
              if (in_range_new) begin
                result_d.acted   = valid_q[tgt_new];
                valid_d[tgt_new] = 1'b0;
              end
            end
            KindClearAll: begin
              done_d         = 1'b1;
              result_d.acted = |valid_q;
              valid_d        = '0;
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      // an empty slot reads as the maximum limit
      StLoad: req_d = valid_q[tgt_cur] ? rdata_q : max_q;

      StLimChk: begin
        alu_a = AluBits'(min_q);
        alu_b = AluBits'(req_q);
        if (!(ctl_q && alu.lt)) begin
          done_d   = 1'b1;
          result_d = '{limit_value: req_q, acted: 1'b0};
        end
      end

      StLimMax: begin
        alu_a = AluBits'(req_q);
        alu_b = AluBits'(max_q);
      end

      // saturating request less one step
      StStepSub, StPwrReq: begin
        alu_a = AluBits'(req_q);
        alu_b = AluBits'(step_q);
        acc_d = alu.lt ? '0 : alu.res;
      end

      // measured power at or below the floor: drop to the floor
      StPwrMin: begin
        alu_a = AluBits'(min_q);
        alu_b = AluBits'(item_q.measured_power);
        if (!alu.lt) acc_d = '0;
      end

      StPwrStep: begin
        alu_a = AluBits'(item_q.measured_power);
        alu_b = AluBits'(step_q);
        if (alu.lt) acc_d = '0;
        else        tmp_d = alu.res[W-1:0];
      end

      StPwrLeast: begin
        alu_a = acc_q;
        alu_b = AluBits'(tmp_q);
        if (!alu.lt) acc_d = AluBits'(tmp_q);
      end

      // raise to the floor, then write the slot
      StLimFloor: begin
        alu_a     = acc_q;
        alu_b     = AluBits'(min_q);
        mem_wdata = alu.lt ? min_q : acc_q[W-1:0];
        mem_we    = 1'b1;
        valid_d[tgt_cur] = 1'b1;
        done_d    = 1'b1;
        result_d  = '{limit_value: mem_wdata, acted: 1'b1};
      end

      StUpChk: begin
        alu_a = AluBits'(req_q);
        alu_b = AluBits'(max_q);
        if (!(ctl_q && alu.lt)) begin
          done_d   = 1'b1;
          result_d = '{limit_value: req_q, acted: 1'b0};
        end
      end

      StUpAdd: begin
        alu_op = AluAdd;
        alu_a  = AluBits'(req_q);
        alu_b  = AluBits'(step_q);
        acc_d  = alu.res;
      end

      // cap at the maximum, then write the slot
      StUpCap: begin
        alu_a     = acc_q;
        alu_b     = AluBits'(max_q);
        mem_wdata = alu.lt ? acc_q[W-1:0] : max_q;
        mem_we    = 1'b1;
        valid_d[tgt_cur] = 1'b1;
        done_d    = 1'b1;
        result_d  = '{limit_value: mem_wdata, acted: 1'b1};
      end

      // issue a read per cycle and fold in the slot read the cycle before
      StScan: begin
        alu_a = AluBits'(rdata_q);
        alu_b = AluBits'(low_q);
        if (pend_q && vld_q && (!any_q || alu.lt)) begin
          low_d = rdata_q;
          any_d = 1'b1;
        end
        if (!scan_end) begin
          pend_d = 1'b1;
          vld_d  = valid_q[idx_q[IW-1:0]];
          idx_d  = idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      StClampMax: begin
        alu_a = AluBits'(max_q);
        alu_b = AluBits'(low_q);
        if (alu.lt) low_d = max_q;
      end

      // floor applied last so it wins over the ceiling
      StClampMin: begin
        alu_a = AluBits'(low_q);
        alu_b = AluBits'(min_q);
        if (alu.lt) low_d = min_q;
      end

      StCmpIssued: begin
        alu_a    = AluBits'(low_q);
        alu_b    = AluBits'(item_q.issued_limit);
        done_d   = 1'b1;
        result_d = '{limit_value: low_q, acted: !alu.eq};
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      done_q  <= 1'b0;
      any_q   <= 1'b0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      any_q   <= any_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      vld_q   <= vld_d;
    end
  end

  // payload registers hold without reset
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    req_q    <= req_d;
    acc_q    <= acc_d;
    tmp_q    <= tmp_d;
    low_q    <= low_d;
    result_q <= result_d;
  end

endmodule

### hdl/plra_alu.sv
// ----------------------------------------------------------------------------
// plra_alu: shared add / subtract-compare unit
// One adder serves every step: sum, difference, less-than and equality.
// ----------------------------------------------------------------------------
module plra_alu
  import plra_pkg::*;
(
  input  plra_alu_op_e        op_i,
  input  logic [AluBits-1:0]  a_i,
  input  logic [AluBits-1:0]  b_i,
  output plra_alu_res_t       res_o
);

  logic             is_sub;
  logic [AluBits:0] sum;

  assign is_sub = (op_i == AluSub);

  // subtract as a + ~b + 1; carry out low means a < b
  assign sum = {1'b0, a_i} + {1'b0, (is_sub ? ~b_i : b_i)} + (AluBits + 1)'(is_sub);

  assign res_o.res = sum[AluBits-1:0];
  assign res_o.lt  = is_sub & ~sum[AluBits];
  assign res_o.eq  = (sum[AluBits-1:0] == '0);

endmodule
